// File: hdl/lppe_pkg.sv
// ----------------------------------------------------------------------------
// lppe_pkg
// Shared types, register indexes and helpers of the LED pixel pulse encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lppe_pkg;

  localparam int unsigned COLOR_BITS     = 8;
  localparam int unsigned PIXEL_BITS     = 24;
  localparam int unsigned TICK_BITS      = 15;
  localparam int unsigned CFG_DATA_BITS  = 15;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned BIT_CNT_BITS   = 5;
  localparam int unsigned PRODUCT_BITS   = 2 * COLOR_BITS;
  localparam int unsigned OUT_DATA_BITS  = 32;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_BRIGHTNESS = 3'd0;
  localparam cfg_index_t REG_ONE_HIGH   = 3'd1;
  localparam cfg_index_t REG_ONE_LOW    = 3'd2;
  localparam cfg_index_t REG_ZERO_HIGH  = 3'd3;
  localparam cfg_index_t REG_ZERO_LOW   = 3'd4;

  localparam logic [COLOR_BITS-1:0] BRIGHTNESS_RESET = 8'd255;
  localparam logic [TICK_BITS-1:0]  ONE_HIGH_RESET   = 15'd32;
  localparam logic [TICK_BITS-1:0]  ONE_LOW_RESET    = 15'd18;
  localparam logic [TICK_BITS-1:0]  ZERO_HIGH_RESET  = 15'd16;
  localparam logic [TICK_BITS-1:0]  ZERO_LOW_RESET   = 15'd34;

  localparam logic [BIT_CNT_BITS-1:0] LAST_BIT = 5'(PIXEL_BITS - 1);

  typedef struct packed {
    logic [TICK_BITS-1:0] one_high;
    logic [TICK_BITS-1:0] one_low;
    logic [TICK_BITS-1:0] zero_high;
    logic [TICK_BITS-1:0] zero_low;
  } timing_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] word;
    logic                  frame_end;
  } pixel_t;

  // floor(x / 255) for x below 65280
  function automatic logic [COLOR_BITS-1:0] div255(input logic [PRODUCT_BITS-1:0] x);
    logic [PRODUCT_BITS:0] sum;
    sum = {1'b0, x} + {9'd0, x[PRODUCT_BITS-1:COLOR_BITS]} + 17'd1;
    return sum[PRODUCT_BITS-1:COLOR_BITS];
  endfunction

endpackage

`default_nettype wire

// File: hdl/led_pixel_pulse_encoder_core.sv
// ----------------------------------------------------------------------------
// led_pixel_pulse_encoder_core
// LED strip pixel encoder: one RGB pixel in, 24 timed pulse items out.
// ----------------------------------------------------------------------------
// Input stream: one pixel per item, red/green/blue in s_tdata, s_tlast marks
// the last pixel of a frame. Each channel is scaled by brightness as
// (c * brightness) / 255, then sent green, red, blue, msb first.
// Output stream: one item per bit with high and low tick counts picked from
// the one-bit or zero-bit timing registers; m_tuser marks the 24th bit of a
// pixel and m_tlast the final bit of the frame.
// The first bit of a pixel comes out after the pixel passes the input
// register, the multiply register, then the shift register.
// The serializer sends one bit per cycle while m_tready is high; the next
// pixel waits in the two-stage front end and loads in the cycle the previous
// pixel's last bit is taken, so bits stream with no gaps.
// Reset clears all valid state and loads brightness 255 and the default
// timings. A stalled m_tready holds the current bit; up to two further pixels
// are then buffered before s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pixel_pulse_encoder_core #(
  parameter int unsigned DURATION_BITS = 15
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // red [7:0], green [15:8], blue [23:16]
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  input  wire logic [lppe_pkg::PIXEL_BITS-1:0]        s_tdata,
  input  wire logic                                   s_tlast,
  // high_ticks [14:0], low_ticks [29:15], data_bit [30], zero [31]
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  output logic [lppe_pkg::OUT_DATA_BITS-1:0]          m_tdata,
  // pixel_last [0]
  output logic                                        m_tuser,
  output logic                                        m_tlast,
  input  wire logic                                   cfg_we,
  input  wire lppe_pkg::cfg_index_t                   cfg_index,
  input  wire logic [lppe_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  logic [lppe_pkg::COLOR_BITS-1:0] brightness;
  lppe_pkg::timing_t               timing;
  logic                            pix_valid;
  logic                            pix_ready;
  lppe_pkg::pixel_t                pix;

  lppe_cfg_regs #(
    .DURATION_BITS (DURATION_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .brightness (brightness),
    .timing     (timing)
  );

  lppe_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .brightness (brightness),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix        (pix)
  );

  lppe_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .timing    (timing),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// File: hdl/lppe_cfg_regs.sv
// ----------------------------------------------------------------------------
// lppe_cfg_regs
// Brightness and pulse timing registers, written through the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module lppe_cfg_regs #(
  parameter int unsigned DURATION_BITS = 15
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire lppe_pkg::cfg_index_t                  cfg_index,
  input  wire logic [lppe_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic      [lppe_pkg::COLOR_BITS-1:0]       brightness,
  output lppe_pkg::timing_t                          timing
);

  localparam int unsigned TB = lppe_pkg::TICK_BITS;
  localparam int unsigned DB = DURATION_BITS;

  logic [DURATION_BITS-1:0] one_high;
  logic [DURATION_BITS-1:0] one_low;
  logic [DURATION_BITS-1:0] zero_high;
  logic [DURATION_BITS-1:0] zero_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= lppe_pkg::BRIGHTNESS_RESET;
      one_high   <= DB'(lppe_pkg::ONE_HIGH_RESET);
      one_low    <= DB'(lppe_pkg::ONE_LOW_RESET);
      zero_high  <= DB'(lppe_pkg::ZERO_HIGH_RESET);
      zero_low   <= DB'(lppe_pkg::ZERO_LOW_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lppe_pkg::REG_BRIGHTNESS: brightness <= cfg_data[lppe_pkg::COLOR_BITS-1:0];
        lppe_pkg::REG_ONE_HIGH:   one_high   <= DB'(cfg_data);
        lppe_pkg::REG_ONE_LOW:    one_low    <= DB'(cfg_data);
        lppe_pkg::REG_ZERO_HIGH:  zero_high  <= DB'(cfg_data);
        lppe_pkg::REG_ZERO_LOW:   zero_low   <= DB'(cfg_data);
        default: ;
      endcase
    end
  end

  assign timing.one_high  = TB'(one_high);
  assign timing.one_low   = TB'(one_low);
  assign timing.zero_high = TB'(zero_high);
  assign timing.zero_low  = TB'(zero_low);

endmodule

`default_nettype wire

// File: hdl/lppe_scale.sv
// ----------------------------------------------------------------------------
// lppe_scale
// Input register and brightness scaling, handing a GRB word to the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module lppe_scale (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [lppe_pkg::PIXEL_BITS-1:0]   s_tdata,
  input  wire logic                              s_tlast,
  input  wire logic [lppe_pkg::COLOR_BITS-1:0]   brightness,
  output logic                                   pix_valid,
  input  wire logic                              pix_ready,
  output lppe_pkg::pixel_t                       pix
);

  localparam int unsigned CB = lppe_pkg::COLOR_BITS;
  localparam int unsigned PB = lppe_pkg::PRODUCT_BITS;

  logic          a_vld;
  logic [CB-1:0] a_red;
  logic [CB-1:0] a_green;
  logic [CB-1:0] a_blue;
  logic          a_fe;
  logic          a_ready;

  logic          b_vld;
  logic [PB-1:0] b_red;
  logic [PB-1:0] b_green;
  logic [PB-1:0] b_blue;
  logic          b_fe;
  logic          b_ready;

  assign b_ready  = !b_vld || pix_ready;
  assign a_ready  = !a_vld || b_ready;
  assign s_tready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      if (a_ready) begin
        a_vld <= s_tvalid;
      end
      if (b_ready) begin
        b_vld <= a_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_tvalid) begin
      a_red   <= s_tdata[CB-1:0];
      a_green <= s_tdata[2*CB-1:CB];
      a_blue  <= s_tdata[3*CB-1:2*CB];
      a_fe    <= s_tlast;
    end
    if (b_ready && a_vld) begin
      b_red   <= PB'(a_red) * PB'(brightness);
      b_green <= PB'(a_green) * PB'(brightness);
      b_blue  <= PB'(a_blue) * PB'(brightness);
      b_fe    <= a_fe;
    end
  end

  assign pix_valid     = b_vld;
  assign pix.word      = {lppe_pkg::div255(b_green), lppe_pkg::div255(b_red),
                          lppe_pkg::div255(b_blue)};
  assign pix.frame_end = b_fe;

endmodule

`default_nettype wire

// File: hdl/lppe_serializer.sv
// ----------------------------------------------------------------------------
// lppe_serializer
// Shifts a GRB word out msb first, one pulse item per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lppe_serializer (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 pix_valid,
  output logic                                      pix_ready,
  input  wire lppe_pkg::pixel_t                     pix,
  input  wire lppe_pkg::timing_t                    timing,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [lppe_pkg::OUT_DATA_BITS-1:0]        m_tdata,
  output logic                                      m_tuser,
  output logic                                      m_tlast
);

  localparam int unsigned WB = lppe_pkg::PIXEL_BITS;
  localparam int unsigned NB = lppe_pkg::BIT_CNT_BITS;

  logic          active;
  logic [NB-1:0] cnt;
  logic [WB-1:0] shreg;
  logic          fe;
  logic          last_bit;
  logic          take;
  logic          load;
  logic          cur_bit;

  assign last_bit  = (cnt == lppe_pkg::LAST_BIT);
  assign take      = active && m_tready;
  assign pix_ready = !active || (take && last_bit);
  assign load      = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (load) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (take) begin
      if (last_bit) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt + NB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= pix.word;
      fe    <= pix.frame_end;
    end else if (take) begin
      shreg <= {shreg[WB-2:0], 1'b0};
    end
  end

  assign cur_bit  = shreg[WB-1];
  assign m_tvalid = active;
  assign m_tdata  = {1'b0, cur_bit,
                     cur_bit ? timing.one_low  : timing.zero_low,
                     cur_bit ? timing.one_high : timing.zero_high};
  assign m_tuser  = last_bit;
  assign m_tlast  = last_bit && fe;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    active |-> cnt <= lppe_pkg::LAST_BIT)
    else $error("bit counter past last bit");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    take && !last_bit && !load |=> m_tvalid && cnt == NB'($past(cnt) + NB'(1)))
    else $error("serializer did not advance one bit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(shreg) && $stable(cnt))
    else $error("stalled item changed");

  a_load: assert property (@(posedge clk) disable iff (rst)
    load |=> m_tvalid && cnt == '0)
    else $error("load did not restart the pixel");

  a_frame_on_pixel: assert property (@(posedge clk) disable iff (rst)
    m_tlast |-> m_tuser)
    else $error("frame end away from pixel end");

endmodule

`default_nettype wire

// File: test/lppe_pulse_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lppe_pulse_checker
// Follows the register writes and the pixels taken by the encoder, works out
// the 24 pulses owed for each pixel and compares every pulse item that leaves
// the block, field by field, with the oldest pulse still owed.
// ----------------------------------------------------------------------------
module lppe_pulse_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  input  wire logic                                s_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  wire logic [lppe_pkg::PIXEL_BITS-1:0]     s_tdata,
  input  wire logic                                s_tlast,
  input  wire logic                                m_tvalid,
  input  wire logic                                m_tready,
  // high_ticks [14:0], low_ticks [29:15], data_bit [30], zero [31]
  input  wire logic [lppe_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  // pixel_last [0]
  input  wire logic                                m_tuser,
  input  wire logic                                m_tlast,
  input  wire logic                                cfg_we,
  input  wire lppe_pkg::cfg_index_t                cfg_index,
  input  wire logic [lppe_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                       mismatches,
  output int                                       pulses_owed
);

  typedef struct packed {
    logic [lppe_pkg::TICK_BITS-1:0] high_ticks;
    logic [lppe_pkg::TICK_BITS-1:0] low_ticks;
    logic                           data_bit;
    logic                           pixel_last;
    logic                           frame_last;
  } pulse_t;

  logic [lppe_pkg::COLOR_BITS-1:0] brightness;
  lppe_pkg::timing_t               timing;
  pulse_t                          owed_q[$];

  initial begin
    mismatches  = 0;
    pulses_owed = 0;
  end

  function automatic logic [7:0] dim(input logic [7:0] level, input logic [7:0] scale);
    int unsigned product;
    product = 32'(level) * 32'(scale);
    return 8'(product / 255);
  endfunction

  task automatic report(input string field, input int got, input int want);
    if (mismatches < 40)
      $display("[%0t] pulse %s mismatch: got %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  // green, red, blue, msb first
  task automatic queue_pixel(input logic [23:0] rgb, input logic frame_end);
    logic [23:0] grb;
    pulse_t      pulse;
    grb = {dim(rgb[15:8], brightness), dim(rgb[7:0], brightness),
           dim(rgb[23:16], brightness)};
    for (int k = 23; k >= 0; k--) begin
      pulse.data_bit   = grb[k];
      pulse.high_ticks = grb[k] ? timing.one_high : timing.zero_high;
      pulse.low_ticks  = grb[k] ? timing.one_low : timing.zero_low;
      pulse.pixel_last = (k == 0);
      pulse.frame_last = (k == 0) && frame_end;
      owed_q.push_back(pulse);
    end
  endtask

  task automatic check_pulse;
    pulse_t want;
    if (owed_q.size() == 0) begin
      report("item with no pixel owed", int'(m_tdata), 0);
    end else begin
      want = owed_q.pop_front();
      if (m_tdata[14:0] !== want.high_ticks)
        report("high_ticks", int'(m_tdata[14:0]), int'(want.high_ticks));
      if (m_tdata[29:15] !== want.low_ticks)
        report("low_ticks", int'(m_tdata[29:15]), int'(want.low_ticks));
      if (m_tdata[30] !== want.data_bit)
        report("data_bit", int'(m_tdata[30]), int'(want.data_bit));
      if (m_tdata[31] !== 1'b0)
        report("padding", int'(m_tdata[31]), 0);
      if (m_tuser !== want.pixel_last)
        report("pixel_last", int'(m_tuser), int'(want.pixel_last));
      if (m_tlast !== want.frame_last)
        report("frame_last", int'(m_tlast), int'(want.frame_last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      brightness <= lppe_pkg::BRIGHTNESS_RESET;
      timing     <= {lppe_pkg::ONE_HIGH_RESET, lppe_pkg::ONE_LOW_RESET,
                     lppe_pkg::ZERO_HIGH_RESET, lppe_pkg::ZERO_LOW_RESET};
      owed_q.delete();
      pulses_owed <= 0;
    end else begin
      if (m_tvalid && m_tready) check_pulse();
      if (s_tvalid && s_tready) queue_pixel(s_tdata, s_tlast);
      if (cfg_we) begin
        case (cfg_index)
          lppe_pkg::REG_BRIGHTNESS: brightness       <= cfg_data[7:0];
          lppe_pkg::REG_ONE_HIGH:   timing.one_high  <= cfg_data;
          lppe_pkg::REG_ONE_LOW:    timing.one_low   <= cfg_data;
          lppe_pkg::REG_ZERO_HIGH:  timing.zero_high <= cfg_data;
          lppe_pkg::REG_ZERO_LOW:   timing.zero_low  <= cfg_data;
          default: ;
        endcase
      end
      pulses_owed <= owed_q.size();
    end
  end

endmodule

// File: test/led_pixel_pulse_encoder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_pixel_pulse_encoder_core_tb
// Drives pixels and register writes into the LED pulse encoder: a directed
// set at the channel and timing extremes, then random pixels under several
// random settings, with random gaps on both streams and one long output hold.
// A checker beside the block predicts and compares every pulse item.
// ----------------------------------------------------------------------------
module led_pixel_pulse_encoder_core_tb;

  localparam int unsigned CYCLE_LIMIT      = 2_000_000;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned RANDOM_PHASES    = 5;
  localparam int unsigned PIXELS_PER_PHASE = 50;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned END_CYCLES       = 20;
  localparam logic [14:0] TICK_MAX         = 15'h7FFF;
  localparam lppe_pkg::cfg_index_t FIRST_UNUSED_REG = 3'd5;
  localparam lppe_pkg::cfg_index_t LAST_UNUSED_REG  = 3'd7;

  logic                                    clk       = 1'b0;
  logic                                    rst       = 1'b1;
  logic                                    s_tvalid  = 1'b0;
  logic                                    s_tready;
  logic [lppe_pkg::PIXEL_BITS-1:0]         s_tdata   = '0;
  logic                                    s_tlast   = 1'b0;
  logic                                    m_tvalid;
  logic                                    m_tready  = 1'b0;
  logic [lppe_pkg::OUT_DATA_BITS-1:0]      m_tdata;
  logic                                    m_tuser;
  logic                                    m_tlast;
  logic                                    cfg_we    = 1'b0;
  lppe_pkg::cfg_index_t                    cfg_index = lppe_pkg::REG_BRIGHTNESS;
  logic [lppe_pkg::CFG_DATA_BITS-1:0]      cfg_data  = '0;

  int          mismatches;
  int          pulses_owed;
  int unsigned cycle_count  = 0;
  bit          sender_burst = 1'b0;
  bit          hold_req     = 1'b0;

  led_pixel_pulse_encoder_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lppe_pulse_checker pulse_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .pulses_owed (pulses_owed)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    else if (pick < 85) return $urandom_range(1, 3);
    else if (pick < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [14:0] rand_ticks();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    else if (pick == 1) return TICK_MAX;
    else return 15'($urandom);
  endfunction

  // upper bits random, low byte often at an extreme
  function automatic logic [14:0] rand_brightness();
    int unsigned pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) return {7'($urandom), 8'd0};
    else if (pick == 1) return {7'($urandom), 8'd255};
    else return 15'($urandom);
  endfunction

  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic frame_end);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {blue, green, red};
    s_tlast  <= frame_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = sender_burst ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_pixel;
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  task automatic write_reg(input lppe_pkg::cfg_index_t index, input logic [14:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [14:0] level, input logic [14:0] one_high,
                           input logic [14:0] one_low, input logic [14:0] zero_high,
                           input logic [14:0] zero_low);
    write_reg(lppe_pkg::REG_BRIGHTNESS, level);
    write_reg(lppe_pkg::REG_ONE_HIGH, one_high);
    write_reg(lppe_pkg::REG_ONE_LOW, one_low);
    write_reg(lppe_pkg::REG_ZERO_HIGH, zero_high);
    write_reg(lppe_pkg::REG_ZERO_LOW, zero_low);
    cfg_we <= 1'b0;
  endtask

  // stop sending, let every owed pulse come out, then a few quiet cycles
  task automatic settle;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pulses_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // output side
  initial begin
    int unsigned run_left;
    int unsigned stall_left;
    run_left   = 0;
    stall_left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
          stall_left = idle_len();
        end
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
    send_pixel(8'h80, 8'h01, 8'h80, 1'b0);
    send_pixel(8'h01, 8'h80, 8'h01, 1'b1);
    send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
    send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
    send_pixel(8'h7F, 8'hFE, 8'h7F, 1'b1);

    // zero brightness, longest durations
    settle();
    configure(15'd0, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'hFF, 1'b1);

    // unused upper bits of brightness, zero durations
    settle();
    configure(15'h7F01, 15'd0, 15'd0, 15'd0, 15'd0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'hFE, 8'hFD, 8'h80, 1'b0);

    // writes to unused indexes must change nothing
    settle();
    for (int k = 0; k <= LAST_UNUSED_REG - FIRST_UNUSED_REG; k++)
      write_reg(lppe_pkg::cfg_index_t'(FIRST_UNUSED_REG + k), k[0] ? 15'd0 : TICK_MAX);
    configure(15'd128, 15'd1, TICK_MAX, 15'd0, 15'h2AAA);
    send_pixel(8'hFF, 8'h01, 8'h02, 1'b0);
    send_pixel(8'hC3, 8'h3C, 8'h99, 1'b1);
    send_pixel(8'h00, 8'hFF, 8'h7F, 1'b0);

    settle();
    configure(15'd254, lppe_pkg::ONE_HIGH_RESET, lppe_pkg::ONE_LOW_RESET,
              lppe_pkg::ZERO_HIGH_RESET, lppe_pkg::ZERO_LOW_RESET);
    send_pixel(8'hFF, 8'h01, 8'hFE, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      if ($urandom_range(0, 1) == 1)
        write_reg(lppe_pkg::cfg_index_t'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)),
                  15'($urandom));
      configure(rand_brightness(), rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
      sender_burst = (phase == 1) || (phase == 3);
      if (phase == 1) hold_req = 1'b1;
      for (int n = 0; n < PIXELS_PER_PHASE; n++) send_random_pixel();
    end
    sender_burst = 1'b0;

    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && pulses_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
